// ===== hw/rtl/wsg_pkg.sv =====
// Shared types and constants of the eight-channel wavetable sound generator.
// Used by the top level and the checker. No dependencies.
package wsg_pkg;

	// Host operation codes carried on the operation field.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ADDR  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	localparam int RAM_DEPTH = 128;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	// Number of ticks between two channel updates.
	localparam int TICK_PERIOD = 15;
	localparam int TICK_W      = $clog2(TICK_PERIOD + 1);

	// Sound RAM byte that holds the channel count in bits 6..4.
	localparam logic [RAM_AW-1:0] CFG_ADDR = 7'h7F;

	// Audio range limits of the mixed sum.
	localparam int AUDIO_MIN = -960;
	localparam int AUDIO_MAX = 840;

endpackage

// ===== hw/rtl/wsg_ram.sv =====
// Generic single-port RAM with a registered read port.
// No dependencies.
module wsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== hw/rtl/wavetable_sound_generator_8ch_unit.sv =====
// Top level of the eight-channel 4-bit wavetable sound generator.
// Depends on wsg_pkg and wsg_ram.
//
// The host drives one beat per operation (tick, data port write, address port
// write, data port read) and receives exactly one result beat for each. The
// block handles one operation at a time: in_stall is high from the beat's
// acceptance until its result is staged in the output register, and the next
// beat may be accepted while that result still waits to be taken. Port
// operations and ticks that do not update a channel pass from the accept
// cycle straight to staging the result. Every fifteenth tick updates one
// channel: the accept cycle, a read of the channel's eight bytes and the count
// byte through the single RAM port, an add of the frequency to the phase,
// seven passes of the shared compare-subtract unit that reduces the phase by
// the wave length, three write-backs, a read of the wave nibble, one add per
// enabled channel for the mix, and the staging of the result. After reset the
// block runs a pass that clears all 128 bytes of the sound RAM, during which
// in_stall stays high.
module wavetable_sound_generator_8ch_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic signed [10:0] audio_out
);

	// Sequencer states, one-hot.
	typedef enum logic [11:0] {
		ST_CLEAR    = 12'h001,
		ST_IDLE     = 12'h002,
		ST_FETCH    = 12'h004,
		ST_ADD      = 12'h008,
		ST_MOD      = 12'h010,
		ST_WB       = 12'h020,
		ST_NIB_RD   = 12'h040,
		ST_NIB_WAIT = 12'h080,
		ST_SUM      = 12'h100,
		ST_DONE     = 12'h200,
		ST_SPARE0   = 12'h400,
		ST_SPARE1   = 12'h800
	} state_t;

	state_t state_q;

	logic [wsg_pkg::RAM_AW-1:0] clr_idx_q;
	logic [wsg_pkg::RAM_AW-1:0] port_addr_q;
	logic                       auto_inc_q;
	logic [wsg_pkg::TICK_W-1:0] tick_cnt_q;
	logic [2:0]                 serve_ch_q;
	logic [2:0]                 lowest_q;
	logic [1:0]                 op_q;

	// Channel bytes as read from the RAM, in byte order 0..7.
	logic [7:0]  chan_q [8];
	logic [3:0]  fetch_idx_q;
	logic [8:0]  rem_q;       // phase bits 24..16 during the reduction
	logic [15:0] low16_q;     // phase bits 15..0
	logic [8:0]  mod_q;       // wave length in units of 65536
	logic [2:0]  k_q;         // shift of the current reduction pass
	logic [1:0]  wb_idx_q;
	logic        nib_hi_q;

	logic signed [7:0]  level_q [8];
	logic signed [10:0] acc_q;
	logic signed [10:0] mixed_q;
	logic [2:0]         sum_idx_q;

	logic out_valid_q;
	logic [7:0] read_data_q;
	logic signed [10:0] audio_out_q;

	// RAM port.
	logic                       ram_we;
	logic                       ram_re;
	logic [wsg_pkg::RAM_AW-1:0] ram_addr;
	logic [7:0]                 ram_wdata;
	logic [7:0]                 ram_rdata;

	wsg_ram #(
		.WIDTH(8),
		.DEPTH(wsg_pkg::RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	logic in_accept;
	logic out_free;
	logic op_port;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign op_port   = (operation == wsg_pkg::OP_WRITE) || (operation == wsg_pkg::OP_READ);

	// Shared compare-subtract unit of the phase reduction.
	logic [14:0] mod_shift;
	logic [14:0] rem_ext;
	logic [14:0] rem_diff;
	logic        rem_ge;

	assign mod_shift = {6'b0, mod_q} << k_q;
	assign rem_ext   = {6'b0, rem_q};
	assign rem_diff  = rem_ext - mod_shift;
	assign rem_ge    = (rem_ext >= mod_shift);

	// Phase plus frequency, both assembled from the fetched bytes.
	logic [24:0] phase_sum;
	assign phase_sum = {1'b0, chan_q[5], chan_q[3], chan_q[1]}
		+ {7'b0, chan_q[4][1:0], chan_q[2], chan_q[0]};

	// Wave nibble address: whole phase plus wave start, modulo 256.
	logic [7:0] nib_addr;
	assign nib_addr = rem_q[7:0] + chan_q[6];

	// Channel level: centered nibble times volume.
	logic [3:0]         nibble;
	logic signed [4:0]  nib_ctr;
	logic signed [9:0]  level_prod;

	assign nibble     = nib_hi_q ? ram_rdata[7:4] : ram_rdata[3:0];
	assign nib_ctr    = $signed({1'b0, nibble}) - 5'sd8;
	assign level_prod = $signed({{5{nib_ctr[4]}}, nib_ctr}) * $signed({6'b0, chan_q[7][3:0]});

	logic signed [10:0] level_ext;
	assign level_ext = {{3{level_q[sum_idx_q][7]}}, level_q[sum_idx_q]};

	// RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = port_addr_q;
		ram_wdata = data;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_idx_q;
				ram_wdata = 8'h00;
			end
			ST_IDLE: begin
				ram_we = in_accept && (operation == wsg_pkg::OP_WRITE);
				ram_re = in_accept && (operation == wsg_pkg::OP_READ);
			end
			ST_FETCH: begin
				ram_re = (fetch_idx_q <= 4'd8);
				if (fetch_idx_q == 4'd0) begin
					ram_addr = wsg_pkg::CFG_ADDR;
				end else begin
					ram_addr = {1'b1, serve_ch_q, 3'(fetch_idx_q - 4'd1)};
				end
			end
			ST_WB: begin
				ram_we = 1'b1;
				case (wb_idx_q)
					2'd0: begin
						ram_addr  = {1'b1, serve_ch_q, 3'd5};
						ram_wdata = rem_q[7:0];
					end
					2'd1: begin
						ram_addr  = {1'b1, serve_ch_q, 3'd3};
						ram_wdata = low16_q[15:8];
					end
					default: begin
						ram_addr  = {1'b1, serve_ch_q, 3'd1};
						ram_wdata = low16_q[7:0];
					end
				endcase
			end
			ST_NIB_RD: begin
				ram_re   = 1'b1;
				ram_addr = nib_addr[7:1];
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			port_addr_q <= '0;
			auto_inc_q  <= 1'b0;
			tick_cnt_q  <= wsg_pkg::TICK_W'(wsg_pkg::TICK_PERIOD);
			serve_ch_q  <= 3'd7;
			mixed_q     <= '0;
			fetch_idx_q <= '0;
			wb_idx_q    <= '0;
			k_q         <= '0;
			sum_idx_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				level_q[i] <= '0;
			end
		end else begin
			// A taken result clears the output register unless a new one is
			// staged in the same cycle.
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == wsg_pkg::RAM_AW'(wsg_pkg::RAM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						op_q    <= operation;
						state_q <= ST_DONE;
						if (op_port && auto_inc_q) begin
							port_addr_q <= port_addr_q + 1'b1;
						end
						if (operation == wsg_pkg::OP_ADDR) begin
							port_addr_q <= data[6:0];
							auto_inc_q  <= data[7];
						end
						if (operation == wsg_pkg::OP_TICK) begin
							if (tick_cnt_q <= wsg_pkg::TICK_W'(1)) begin
								tick_cnt_q  <= wsg_pkg::TICK_W'(wsg_pkg::TICK_PERIOD);
								fetch_idx_q <= '0;
								state_q     <= ST_FETCH;
							end else begin
								tick_cnt_q <= tick_cnt_q - 1'b1;
							end
						end
					end
				end
				ST_FETCH: begin
					fetch_idx_q <= fetch_idx_q + 1'b1;
					if (fetch_idx_q == 4'd1) begin
						lowest_q <= ~ram_rdata[6:4];
					end
					if (fetch_idx_q >= 4'd2) begin
						chan_q[3'(fetch_idx_q - 4'd2)] <= ram_rdata;
					end
					if (fetch_idx_q == 4'd9) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					rem_q   <= phase_sum[24:16];
					low16_q <= phase_sum[15:0];
					mod_q   <= 9'd256 - {1'b0, chan_q[4][7:2], 2'b00};
					k_q     <= 3'd6;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (rem_ge) begin
						rem_q <= rem_diff[8:0];
					end
					k_q <= k_q - 1'b1;
					if (k_q == 3'd0) begin
						wb_idx_q <= '0;
						state_q  <= ST_WB;
					end
				end
				ST_WB: begin
					wb_idx_q <= wb_idx_q + 1'b1;
					if (wb_idx_q == 2'd2) begin
						state_q <= ST_NIB_RD;
					end
				end
				ST_NIB_RD: begin
					nib_hi_q <= nib_addr[0];
					state_q  <= ST_NIB_WAIT;
				end
				ST_NIB_WAIT: begin
					level_q[serve_ch_q] <= level_prod[7:0];
					acc_q               <= '0;
					sum_idx_q           <= lowest_q;
					serve_ch_q          <= (serve_ch_q <= lowest_q) ? 3'd7 : serve_ch_q - 1'b1;
					state_q             <= ST_SUM;
				end
				ST_SUM: begin
					acc_q     <= acc_q + level_ext;
					sum_idx_q <= sum_idx_q + 1'b1;
					if (sum_idx_q == 3'd7) begin
						mixed_q <= acc_q + level_ext;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						read_data_q <= (op_q == wsg_pkg::OP_READ) ? ram_rdata : 8'h00;
						audio_out_q <= mixed_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign audio_out = audio_out_q;

endmodule

// ===== hw/rtl/wsg_checker.sv =====
// Port-level checker of the wavetable sound generator, bound to the top level.
// Depends on wsg_pkg and wavetable_sound_generator_8ch_unit.
module wsg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  operation,
	input logic [7:0]  data,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  read_data,
	input logic signed [10:0] audio_out
);

	// A result that is held back keeps its valid and payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(audio_out))
		else $error("stalled result beat changed");

	// One operation at a time: an accepted beat makes the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while the previous beat is in work");

	// The mixed sum never leaves the range eight channels can reach.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (audio_out >= 11'(wsg_pkg::AUDIO_MIN)) && (audio_out <= 11'(wsg_pkg::AUDIO_MAX)))
		else $error("audio output out of range");

	// A beat that is not a data port read returns a zero read byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation != wsg_pkg::OP_READ) && !out_valid
		|=> ##1 !out_valid || (read_data == 8'h00))
		else $error("nonzero read byte for a non-read operation");

endmodule

bind wavetable_sound_generator_8ch_unit wsg_checker u_wsg_checker (.*);

// ===== sim/tb_wavetable_sound_generator_8ch_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the eight-channel wavetable sound generator.
// Depends on wsg_pkg and the RTL of wavetable_sound_generator_8ch_unit.
module tb_wavetable_sound_generator_8ch_unit;

	// The run is ended by force if it has not finished by this many cycles.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_BEATS  = 1900;
	localparam int MAX_REPORTS   = 10;
	// Cycles to wait after the last result, enough for the slowest channel update.
	localparam int DRAIN_CYCLES  = 40;
	// Beat numbers between which neither side idles.
	localparam int QUIET_FIRST   = 700;
	localparam int QUIET_LAST    = 1000;
	localparam logic [6:0] CHANNEL_BASE = 7'h40;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        operation;
	logic [7:0]        data;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        read_data;
	logic signed [10:0] audio_out;

	wavetable_sound_generator_8ch_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.data      (data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_data (read_data),
		.audio_out (audio_out)
	);

	// One result beat: the byte read back and the mixed audio level.
	typedef struct packed {
		logic [7:0]         rd;
		logic signed [10:0] au;
	} result_t;

	// One row of the directed sequence. When fixed is set, the expected result
	// is the one written in the row; otherwise the predictor supplies it.
	typedef struct packed {
		wsg_pkg::op_t       op;
		logic [7:0]         d;
		logic [4:0]         reps;
		logic               fixed;
		logic [7:0]         rd;
		logic signed [10:0] au;
	} stim_row_t;

	localparam int NUM_ROWS = 25;

	// The directed part walks channel 7 through a phase wrap at the largest wave
	// length, then channel 6 through the smallest wave length with a nibble
	// address that wraps past the end of the RAM. The channel count is dropped
	// to one while channel 6 is next in line, so a channel below the lowest
	// enabled one is served once before the rotation returns to channel 7.
	stim_row_t directed_rows [NUM_ROWS] = '{
		'{wsg_pkg::OP_READ,  8'h00, 5'd1,  1'b1, 8'h00, 11'sd0},  // RAM is clear after reset
		'{wsg_pkg::OP_ADDR,  8'hFF, 5'd1,  1'b1, 8'h00, 11'sd0},  // 0x7F, auto-increment on
		'{wsg_pkg::OP_WRITE, 8'h70, 5'd1,  1'b1, 8'h00, 11'sd0},  // all channels, address wraps
		'{wsg_pkg::OP_READ,  8'h00, 5'd1,  1'b1, 8'h00, 11'sd0},
		'{wsg_pkg::OP_ADDR,  8'h7F, 5'd1,  1'b1, 8'h00, 11'sd0},  // 0x7F, auto-increment off
		'{wsg_pkg::OP_READ,  8'h00, 5'd2,  1'b1, 8'h70, 11'sd0},  // same byte twice, no advance
		'{wsg_pkg::OP_ADDR,  8'hF8, 5'd1,  1'b1, 8'h00, 11'sd0},  // channel 7 registers
		'{wsg_pkg::OP_WRITE, 8'hFF, 5'd2,  1'b1, 8'h00, 11'sd0},
		'{wsg_pkg::OP_WRITE, 8'hFF, 5'd2,  1'b1, 8'h00, 11'sd0},
		'{wsg_pkg::OP_WRITE, 8'h03, 5'd1,  1'b1, 8'h00, 11'sd0},  // top frequency bits, longest wave
		'{wsg_pkg::OP_WRITE, 8'hFF, 5'd1,  1'b1, 8'h00, 11'sd0},
		'{wsg_pkg::OP_WRITE, 8'h00, 5'd1,  1'b1, 8'h00, 11'sd0},
		'{wsg_pkg::OP_WRITE, 8'h7F, 5'd1,  1'b1, 8'h00, 11'sd0},  // full volume, all channels
		'{wsg_pkg::OP_TICK,  8'h00, 5'd14, 1'b1, 8'h00, 11'sd0},
		'{wsg_pkg::OP_TICK,  8'h00, 5'd1,  1'b1, 8'h00, -11'sd120},  // zero nibble, full volume
		'{wsg_pkg::OP_ADDR,  8'hF0, 5'd1,  1'b1, 8'h00, -11'sd120},  // channel 6 registers
		'{wsg_pkg::OP_WRITE, 8'h00, 5'd4,  1'b0, 8'h00, 11'sd0},
		'{wsg_pkg::OP_WRITE, 8'hFF, 5'd3,  1'b0, 8'h00, 11'sd0},  // shortest wave, start at 0xFF
		'{wsg_pkg::OP_WRITE, 8'h0F, 5'd1,  1'b0, 8'h00, 11'sd0},
		'{wsg_pkg::OP_ADDR,  8'hFF, 5'd1,  1'b0, 8'h00, 11'sd0},
		'{wsg_pkg::OP_WRITE, 8'h0F, 5'd1,  1'b0, 8'h00, 11'sd0},  // only channel 7 enabled
		'{wsg_pkg::OP_TICK,  8'h00, 5'd15, 1'b0, 8'h00, 11'sd0},
		'{wsg_pkg::OP_ADDR,  8'h80, 5'd1,  1'b0, 8'h00, 11'sd0},
		'{wsg_pkg::OP_WRITE, 8'hFF, 5'd4,  1'b0, 8'h00, 11'sd0},  // all-ones wave bytes
		'{wsg_pkg::OP_TICK,  8'h00, 5'd15, 1'b0, 8'h00, 11'sd0}
	};

	// Shadow of the generator's state, kept by the predictor.
	logic [7:0]         shadow_ram [128];
	logic signed [7:0]  channel_level [8];
	logic signed [10:0] mixed_level;
	logic [2:0]         serving_channel;
	logic [6:0]         port_address;
	logic               auto_increment;
	int                 tick_countdown;

	result_t pending_outputs [$];
	int      mismatch_count = 0;
	int      beats_sent;
	int      outputs_seen = 0;
	int      cycle_count = 0;
	logic    quiet_stretch;

	assign quiet_stretch = (beats_sent >= QUIET_FIRST) && (beats_sent < QUIET_LAST);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Advances one channel: phase update, nibble fetch, level, mix and rotation.
	function automatic void update_channel();
		int unsigned lowest;
		int unsigned ch;
		int unsigned base;
		int unsigned freq;
		int unsigned phase;
		int unsigned modulus;
		int unsigned nib_addr;
		int          nib;
		int          vol;
		int          sum;
		lowest   = 7 - ((shadow_ram[wsg_pkg::CFG_ADDR] >> 4) & 8'h07);
		ch       = serving_channel;
		base     = CHANNEL_BASE + ch * 8;
		freq     = 32'({shadow_ram[base + 4][1:0], shadow_ram[base + 2], shadow_ram[base]});
		phase    = 32'({shadow_ram[base + 5], shadow_ram[base + 3], shadow_ram[base + 1]});
		modulus  = (32'd256 - {24'd0, shadow_ram[base + 4] & 8'hFC}) << 16;
		phase    = (phase + freq) % modulus;
		shadow_ram[base + 5] = phase[23:16];
		shadow_ram[base + 3] = phase[15:8];
		shadow_ram[base + 1] = phase[7:0];
		// The wave start is counted in nibbles; the low nibble of a byte comes first.
		nib_addr = ((phase >> 16) + shadow_ram[base + 6]) & 8'hFF;
		nib      = int'((shadow_ram[nib_addr >> 1] >> ((nib_addr & 1) * 4)) & 8'h0F);
		vol      = int'(shadow_ram[base + 7][3:0]);
		channel_level[ch] = 8'((nib - 8) * vol);
		sum = 0;
		for (int unsigned i = lowest; i < 8; i++)
			sum += int'(channel_level[i]);
		mixed_level = 11'(sum);
		// A channel at or below the lowest enabled one sends the rotation back to 7.
		serving_channel = (ch <= lowest) ? 3'd7 : 3'(ch - 1);
	endfunction

	// Applies one accepted beat to the shadow state and returns its result.
	function automatic result_t advance_generator(wsg_pkg::op_t op, logic [7:0] d);
		result_t r;
		r.rd = 8'h00;
		case (op)
			wsg_pkg::OP_TICK: begin
				if (tick_countdown != 0)
					tick_countdown--;
				if (tick_countdown == 0) begin
					update_channel();
					tick_countdown = wsg_pkg::TICK_PERIOD;
				end
			end
			wsg_pkg::OP_WRITE: begin
				shadow_ram[port_address] = d;
				if (auto_increment)
					port_address = port_address + 7'd1;
			end
			wsg_pkg::OP_ADDR: begin
				port_address   = d[6:0];
				auto_increment = d[7];
			end
			default: begin
				r.rd = shadow_ram[port_address];
				if (auto_increment)
					port_address = port_address + 7'd1;
			end
		endcase
		r.au = mixed_level;
		return r;
	endfunction

	// Presents one beat, holds it until accepted, and records its expected result.
	// Starts and ends at a falling edge so that valid is assigned once per step.
	task automatic drive_beat(wsg_pkg::op_t op, logic [7:0] d, logic fixed = 1'b0,
			result_t fixed_result = '0);
		result_t predicted;
		while (!quiet_stretch && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		data      <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = advance_generator(op, d);
		pending_outputs.push_back(fixed ? fixed_result : predicted);
		beats_sent++;
		@(negedge clk);
	endtask

	// Points the address port at one channel and fills its eight bytes. The
	// volume byte of channel 7 also sets the channel count.
	task automatic program_channel();
		logic [2:0] ch;
		logic [7:0] vol_byte;
		ch = 3'($urandom_range(0, 7));
		drive_beat(wsg_pkg::OP_ADDR, {1'b1, CHANNEL_BASE + {ch, 3'b000}});
		for (int i = 0; i < 7; i++)
			drive_beat(wsg_pkg::OP_WRITE, 8'($urandom));
		vol_byte = 8'($urandom);
		if ($urandom_range(0, 3) == 0)
			vol_byte[3:0] = 4'hF;
		drive_beat(wsg_pkg::OP_WRITE, vol_byte);
	endtask

	// The receiving side stalls at random, except during the quiet stretch.
	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 14);
	end

	// Every result beat is compared with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			outputs_seen++;
			if (pending_outputs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result beat %0d: read_data %02h audio_out %0d",
						outputs_seen, read_data, audio_out);
			end else begin
				want = pending_outputs.pop_front();
				if (read_data !== want.rd || audio_out !== want.au) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result beat %0d: read_data exp %02h got %02h, audio_out exp %0d got %0d",
							outputs_seen, want.rd, read_data, want.au, audio_out);
				end
			end
		end
	end

	// Watchdog; the limit leaves room for the RAM clearing pass after reset.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_outputs.size());
			$display("[wavetable_sound_generator_8ch_unit] ERROR");
			$finish;
		end
	end

	initial begin
		int random_beats;
		int pick;
		result_t row_result;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		operation      = wsg_pkg::OP_TICK;
		data           = 8'h00;
		beats_sent     = 0;
		random_beats   = 0;

		for (int i = 0; i < 128; i++)
			shadow_ram[i] = 8'h00;
		for (int i = 0; i < 8; i++)
			channel_level[i] = 8'sd0;
		mixed_level     = 11'sd0;
		serving_channel = 3'd7;
		port_address    = 7'd0;
		auto_increment  = 1'b0;
		tick_countdown  = wsg_pkg::TICK_PERIOD;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. The block holds in_stall during its clearing pass,
		// so the first beat simply waits for it.
		for (int r = 0; r < NUM_ROWS; r++) begin
			row_result.rd = directed_rows[r].rd;
			row_result.au = directed_rows[r].au;
			for (int k = 0; k < directed_rows[r].reps; k++)
				drive_beat(directed_rows[r].op, directed_rows[r].d,
					directed_rows[r].fixed, row_result);
		end

		// Random part: mostly ticks and well-formed channel setups with random
		// contents, mixed with stray address, write and read beats.
		while (random_beats < RANDOM_BEATS) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				program_channel();
				random_beats += 9;
			end else if (pick < 9) begin
				drive_beat(wsg_pkg::OP_ADDR, {1'($urandom), wsg_pkg::CFG_ADDR});
				drive_beat(wsg_pkg::OP_WRITE, 8'($urandom));
				random_beats += 2;
			end else if (pick < 15) begin
				// Wave bytes live below the channel registers.
				drive_beat(wsg_pkg::OP_ADDR, {1'b1, 1'b0, 6'($urandom)});
				for (int i = 0; i < 4; i++)
					drive_beat(wsg_pkg::OP_WRITE, 8'($urandom));
				random_beats += 5;
			end else if (pick < 20) begin
				drive_beat(wsg_pkg::OP_ADDR, 8'($urandom));
				random_beats++;
			end else if (pick < 25) begin
				drive_beat(wsg_pkg::OP_WRITE, 8'($urandom));
				random_beats++;
			end else if (pick < 32) begin
				drive_beat(wsg_pkg::OP_READ, 8'($urandom));
				random_beats++;
			end else begin
				drive_beat(wsg_pkg::OP_TICK, 8'($urandom));
				random_beats++;
			end
		end
		in_valid <= 1'b0;

		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("[wavetable_sound_generator_8ch_unit] OK");
		end else begin
			$display("[wavetable_sound_generator_8ch_unit] ERROR");
		end
		$finish;
	end

endmodule
